@@ hdl/fresnel_dielectric_reflectance_assert.svh @@
// Assertion macros used by the Fresnel reflectance top level.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_ASSERT_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FRDR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define FRDR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/frdr_pkg.sv @@
// Constants used by the Fresnel reflectance datapath.
package frdr_pkg;
   localparam int COS_W   = 16;
   localparam int ETA_W   = 14;
   localparam int REFL_W  = 17;
   localparam logic [REFL_W-1:0] ONE_Q16 = 17'h10000;
   localparam int CI_W    = 17;
   localparam int ETA2_W  = 28;
   localparam int COS2_W  = 33;
   localparam int ROOT_W  = 17;
   localparam int RAT_W   = 31;
   localparam int SIDE_W  = 1 + ETA_W + ETA_W + CI_W;
endpackage

@@ hdl/frdr_div_cell.sv @@
// One restoring-division cell: produce one quotient bit per cycle while enabled.
module frdr_div_cell #(
   parameter int DW = 28,
   parameter int NW = 33,
   parameter int QW = 33,
   parameter int SW = 46
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] in_den,
   input  logic [NW-1:0] in_num,
   input  logic [QW-1:0] in_quo,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_rem,
   output logic [DW-1:0] out_den,
   output logic [NW-1:0] out_num,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   logic [DW:0]   trial;
   logic          ge;
   logic [DW:0]   diff;
   logic          valid_ff;
   logic [DW-1:0] rem_ff, rem_in, den_ff;
   logic [NW-1:0] num_ff;
   logic [QW-1:0] quo_ff;
   logic [SW-1:0] side_ff;

   always_comb begin
      trial  = {in_rem, in_num[NW-1]};
      ge     = (trial >= {1'b0, in_den});
      diff   = trial - {1'b0, in_den};
      rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         num_ff  <= in_num << 1;
         quo_ff  <= {in_quo[QW-2:0], ge};
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_num   = num_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;
endmodule

@@ hdl/frdr_sqrt_cell.sv @@
// One digit-by-digit square-root cell: produce one root bit per cycle while enabled.
module frdr_sqrt_cell #(
   parameter int XW = 34,
   parameter int RTW = 17,
   parameter int SW = 46
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic           in_valid,
   input  logic [RTW+2:0] in_rem,
   input  logic [RTW-1:0] in_root,
   input  logic [XW-1:0]  in_x,
   input  logic [SW-1:0]  in_side,
   output logic           out_valid,
   output logic [RTW+2:0] out_rem,
   output logic [RTW-1:0] out_root,
   output logic [XW-1:0]  out_x,
   output logic [SW-1:0]  out_side
);
   localparam int RW = RTW + 3;

   logic [RW+1:0]  cur;
   logic [RW+1:0]  trial;
   logic [RW+1:0]  diff;
   logic           ge;
   logic [RW-1:0]  rem_in, rem_ff;
   logic           valid_ff;
   logic [RTW-1:0] root_ff;
   logic [XW-1:0]  x_ff;
   logic [SW-1:0]  side_ff;

   always_comb begin
      cur    = {in_rem, in_x[XW-1:XW-2]};
      trial  = {3'b000, in_root, 2'b01};
      ge     = (cur >= trial);
      diff   = cur - trial;
      rem_in = ge ? diff[RW-1:0] : cur[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= {in_root[RTW-2:0], ge};
         x_ff    <= in_x << 2;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_x     = x_ff;
   assign out_side  = side_ff;
endmodule

@@ hdl/fresnel_dielectric_reflectance.sv @@
// Top level: pipelined unpolarized Fresnel reflectance for a dielectric boundary.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | cos_incident, eta_incident, eta_transmitted
//  rsp     | out       | rsp_valid/ready    | reflectance, total_internal
//
// One transaction accepted per cycle while req_ready is high.
// The pipeline is made of the cell chains: 33 cosine-division cells, 17 square-root cells
// and 17 amplitude-ratio division cells, plus the multiply and compare stages.
// Synchronous reset clears the valid bits of every stage and the output buffer.
// A two-entry output buffer lets the pipeline advance while one result waits;
// the whole pipeline holds only when both entries are full and rsp_ready is low.
module fresnel_dielectric_reflectance (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [15:0] req_cos_incident,
   input  logic [13:0] req_eta_incident,
   input  logic [13:0] req_eta_transmitted,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] rsp_reflectance,
   output logic        rsp_total_internal
);
   `include "fresnel_dielectric_reflectance_assert.svh"

   localparam int EW  = frdr_pkg::ETA_W;
   localparam int CW  = frdr_pkg::CI_W;
   localparam int E2W = frdr_pkg::ETA2_W;
   localparam int QW1 = frdr_pkg::COS2_W;
   localparam int RTW = frdr_pkg::ROOT_W;
   localparam int RAW = frdr_pkg::RAT_W;
   localparam int SW  = frdr_pkg::SIDE_W;
   localparam int RFW = frdr_pkg::REFL_W;
   localparam int NW1 = QW1;
   localparam int NW2 = RFW;

   logic en;

   // ---------------- stage 1: exchange, magnitude, squares
   logic          swap;
   logic [15:0]   mag;
   logic [EW-1:0] ei_sel, et_sel;
   logic [CW-1:0] ci_sel;
   logic          v1_ff;
   logic [EW-1:0] ei1_ff, et1_ff;
   logic [CW-1:0] ci1_ff;
   logic [2*CW-1:0] cisq1_ff;
   logic [E2W-1:0]  ei2_1_ff, et2_1_ff;

   always_comb begin
      swap   = (req_cos_incident == 16'sd0) || req_cos_incident[15];
      mag    = req_cos_incident[15] ? (16'd0 - req_cos_incident[15:0])
                                    : req_cos_incident[15:0];
      ci_sel = {mag, 1'b0};
      ei_sel = swap ? req_eta_transmitted : req_eta_incident;
      et_sel = swap ? req_eta_incident : req_eta_transmitted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ei1_ff   <= ei_sel;
         et1_ff   <= et_sel;
         ci1_ff   <= ci_sel;
         cisq1_ff <= ci_sel * ci_sel;
         ei2_1_ff <= ei_sel * ei_sel;
         et2_1_ff <= et_sel * et_sel;
      end
   end

   // ---------------- stage 2: sin^2 and partial products of sin^2 * ei^2
   logic [32:0]  s2i;
   logic         v2_ff;
   logic [E2W+16:0] pphi_ff;
   logic [E2W+15:0] pplo_ff;
   logic [EW-1:0]   ei2s_ff, et2s_ff;
   logic [CW-1:0]   ci2_ff;
   logic [E2W-1:0]  etsq2_ff;

   assign s2i = 33'h1_0000_0000 - cisq1_ff[32:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pphi_ff  <= s2i[32:16] * ei2_1_ff;
         pplo_ff  <= s2i[15:0] * ei2_1_ff;
         ei2s_ff  <= ei1_ff;
         et2s_ff  <= et1_ff;
         ci2_ff   <= ci1_ff;
         etsq2_ff <= et2_1_ff;
      end
   end

   // ---------------- stage 3: total internal reflection test
   logic [60:0] lhs, rhs, numer;
   logic        tir3;
   logic        v3_ff, tir3_ff;
   logic [59:0] n3_ff;
   logic [EW-1:0] ei3_ff, et3_ff;
   logic [CW-1:0] ci3_ff;
   logic [E2W-1:0] etsq3_ff;

   always_comb begin
      lhs   = {pphi_ff, 16'd0} + {17'd0, pplo_ff};
      rhs   = {1'b0, etsq2_ff, 32'd0};
      tir3  = (lhs >= rhs);
      numer = rhs - lhs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tir3_ff  <= tir3;
         n3_ff    <= numer[59:0];
         ei3_ff   <= ei2s_ff;
         et3_ff   <= et2s_ff;
         ci3_ff   <= ci2_ff;
         etsq3_ff <= etsq2_ff;
      end
   end

   // ---------------- cos^2(t) division chain
   logic           d1_v    [0:QW1];
   logic [E2W-1:0] d1_rem  [0:QW1];
   logic [E2W-1:0] d1_den  [0:QW1];
   logic [NW1-1:0] d1_num  [0:QW1];
   logic [QW1-1:0] d1_quo  [0:QW1];
   logic [SW-1:0]  d1_side [0:QW1];

   assign d1_v[0]    = v3_ff;
   assign d1_rem[0]  = {1'b0, n3_ff[59:33]};
   assign d1_den[0]  = etsq3_ff;
   assign d1_num[0]  = n3_ff[32:0];
   assign d1_quo[0]  = '0;
   assign d1_side[0] = {tir3_ff, ei3_ff, et3_ff, ci3_ff};

   for (genvar i = 0; i < QW1; i++) begin : g_div_cos
      frdr_div_cell #(.DW(E2W), .NW(NW1), .QW(QW1), .SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (en),
         .in_valid  (d1_v[i]),
         .in_rem    (d1_rem[i]),
         .in_den    (d1_den[i]),
         .in_num    (d1_num[i]),
         .in_quo    (d1_quo[i]),
         .in_side   (d1_side[i]),
         .out_valid (d1_v[i+1]),
         .out_rem   (d1_rem[i+1]),
         .out_den   (d1_den[i+1]),
         .out_num   (d1_num[i+1]),
         .out_quo   (d1_quo[i+1]),
         .out_side  (d1_side[i+1])
      );
   end

   // ---------------- cos(t) square-root chain
   logic           sq_v    [0:RTW];
   logic [RTW+2:0] sq_rem  [0:RTW];
   logic [RTW-1:0] sq_root [0:RTW];
   logic [2*RTW-1:0] sq_x  [0:RTW];
   logic [SW-1:0]  sq_side [0:RTW];

   assign sq_v[0]    = d1_v[QW1];
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_x[0]    = {1'b0, d1_quo[QW1]};
   assign sq_side[0] = d1_side[QW1];

   for (genvar i = 0; i < RTW; i++) begin : g_sqrt
      frdr_sqrt_cell #(.XW(2*RTW), .RTW(RTW), .SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (en),
         .in_valid  (sq_v[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_x      (sq_x[i]),
         .in_side   (sq_side[i]),
         .out_valid (sq_v[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_x     (sq_x[i+1]),
         .out_side  (sq_side[i+1])
      );
   end

   // ---------------- products for the amplitude ratios
   logic          tir_m;
   logic [EW-1:0] ei_m, et_m;
   logic [CW-1:0] ci_m;
   logic          vm_ff, tirm_ff;
   logic [RAW-1:0] p1_ff, q1_ff, p2_ff, q2_ff;

   assign {tir_m, ei_m, et_m, ci_m} = sq_side[RTW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (en) begin
         vm_ff <= sq_v[RTW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tirm_ff <= tir_m;
         p1_ff   <= et_m * ci_m;
         q1_ff   <= ei_m * sq_root[RTW];
         p2_ff   <= ei_m * ci_m;
         q2_ff   <= et_m * sq_root[RTW];
      end
   end

   // ---------------- sums and differences
   logic [RAW:0]   den1, den2;
   logic [RAW-1:0] dif1, dif2;
   logic           vd_ff, tird_ff, zs_ff, zp_ff;
   logic [RAW-1:0] den1_ff, den2_ff, dif1_ff, dif2_ff;

   always_comb begin
      den1 = {1'b0, p1_ff} + {1'b0, q1_ff};
      den2 = {1'b0, p2_ff} + {1'b0, q2_ff};
      dif1 = (p1_ff >= q1_ff) ? (p1_ff - q1_ff) : (q1_ff - p1_ff);
      dif2 = (p2_ff >= q2_ff) ? (p2_ff - q2_ff) : (q2_ff - p2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en) begin
         vd_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tird_ff <= tirm_ff;
         den1_ff <= den1[RAW-1:0];
         den2_ff <= den2[RAW-1:0];
         dif1_ff <= dif1;
         dif2_ff <= dif2;
         zs_ff   <= (den1 == '0);
         zp_ff   <= (den2 == '0);
      end
   end

   // ---------------- amplitude-ratio division chains (s and p in lockstep)
   logic           rs_v    [0:NW2];
   logic [RAW-1:0] rs_rem  [0:NW2];
   logic [RAW-1:0] rs_den  [0:NW2];
   logic [NW2-1:0] rs_num  [0:NW2];
   logic [NW2-1:0] rs_quo  [0:NW2];
   logic [1:0]     rs_side [0:NW2];
   logic           rp_v    [0:NW2];
   logic [RAW-1:0] rp_rem  [0:NW2];
   logic [RAW-1:0] rp_den  [0:NW2];
   logic [NW2-1:0] rp_num  [0:NW2];
   logic [NW2-1:0] rp_quo  [0:NW2];
   logic           rp_side [0:NW2];

   assign rs_v[0]    = vd_ff;
   assign rs_rem[0]  = {1'b0, dif1_ff[RAW-1:1]};
   assign rs_den[0]  = den1_ff;
   assign rs_num[0]  = {dif1_ff[0], {(NW2-1){1'b0}}};
   assign rs_quo[0]  = '0;
   assign rs_side[0] = {tird_ff, zs_ff};
   assign rp_v[0]    = vd_ff;
   assign rp_rem[0]  = {1'b0, dif2_ff[RAW-1:1]};
   assign rp_den[0]  = den2_ff;
   assign rp_num[0]  = {dif2_ff[0], {(NW2-1){1'b0}}};
   assign rp_quo[0]  = '0;
   assign rp_side[0] = zp_ff;

   for (genvar i = 0; i < NW2; i++) begin : g_div_ratio
      frdr_div_cell #(.DW(RAW), .NW(NW2), .QW(NW2), .SW(2)) u_rs (
         .clock     (clock),
         .reset     (reset),
         .enable    (en),
         .in_valid  (rs_v[i]),
         .in_rem    (rs_rem[i]),
         .in_den    (rs_den[i]),
         .in_num    (rs_num[i]),
         .in_quo    (rs_quo[i]),
         .in_side   (rs_side[i]),
         .out_valid (rs_v[i+1]),
         .out_rem   (rs_rem[i+1]),
         .out_den   (rs_den[i+1]),
         .out_num   (rs_num[i+1]),
         .out_quo   (rs_quo[i+1]),
         .out_side  (rs_side[i+1])
      );
      frdr_div_cell #(.DW(RAW), .NW(NW2), .QW(NW2), .SW(1)) u_rp (
         .clock     (clock),
         .reset     (reset),
         .enable    (en),
         .in_valid  (rp_v[i]),
         .in_rem    (rp_rem[i]),
         .in_den    (rp_den[i]),
         .in_num    (rp_num[i]),
         .in_quo    (rp_quo[i]),
         .in_side   (rp_side[i]),
         .out_valid (rp_v[i+1]),
         .out_rem   (rp_rem[i+1]),
         .out_den   (rp_den[i+1]),
         .out_num   (rp_num[i+1]),
         .out_quo   (rp_quo[i+1]),
         .out_side  (rp_side[i+1])
      );
   end

   // ---------------- squares of the ratios
   logic [RFW-1:0]   rs_eff, rp_eff;
   logic             vs_ff, tirs_ff;
   logic [2*RFW-1:0] sqs_ff, sqp_ff;

   assign rs_eff = rs_side[NW2][0] ? frdr_pkg::ONE_Q16 : rs_quo[NW2];
   assign rp_eff = rp_side[NW2] ? frdr_pkg::ONE_Q16 : rp_quo[NW2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else if (en) begin
         vs_ff <= rs_v[NW2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tirs_ff <= rs_side[NW2][1];
         sqs_ff  <= rs_eff * rs_eff;
         sqp_ff  <= rp_eff * rp_eff;
      end
   end

   // ---------------- mean, rounding, saturation
   logic [2*RFW:0]  msum;
   logic [RFW:0]    mean;
   logic [RFW-1:0]  refl_fin;

   always_comb begin
      msum = {1'b0, sqs_ff} + {1'b0, sqp_ff} + (35'd1 << 16);
      mean = msum[2*RFW:RFW];
      if (tirs_ff || (mean > {1'b0, frdr_pkg::ONE_Q16})) begin
         refl_fin = frdr_pkg::ONE_Q16;
      end else begin
         refl_fin = mean[RFW-1:0];
      end
   end

   // ---------------- two-entry output buffer
   logic [1:0]     cnt_ff, cnt_in;
   logic [RFW-1:0] r0_ff, r1_ff;
   logic           t0_ff, t1_ff;
   logic           push, pop;

   assign en   = (cnt_ff != 2'd2) || rsp_ready;
   assign push = vs_ff && en;
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         r0_ff <= r1_ff;
         t0_ff <= t1_ff;
      end
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) begin
            r0_ff <= refl_fin;
            t0_ff <= tirs_ff;
         end else begin
            r1_ff <= refl_fin;
            t1_ff <= tirs_ff;
         end
      end
   end

   assign req_ready          = en;
   assign rsp_valid          = (cnt_ff != 2'd0);
   assign rsp_reflectance    = r0_ff;
   assign rsp_total_internal = t0_ff;

   `FRDR_ASSERT_SAME(a_cnt_range, 1'b1, cnt_ff != 2'd3, "output buffer overfilled")
   `FRDR_ASSERT_SAME(a_tir_one, rsp_valid && rsp_total_internal,
      rsp_reflectance == frdr_pkg::ONE_Q16, "total internal reflection not 1.0")
   `FRDR_ASSERT_SAME(a_sat, rsp_valid, rsp_reflectance <= frdr_pkg::ONE_Q16,
      "reflectance above 1.0")
   `FRDR_ASSERT_SAME(a_full_stall, (cnt_ff == 2'd2) && !rsp_ready, !req_ready,
      "input accepted with full output buffer")
   `FRDR_ASSERT_NEXT(a_push_fill, push && !pop && (cnt_ff == 2'd1), cnt_ff == 2'd2,
      "output buffer count lost a result")
endmodule
